// File: rtl/tss_pkg.sv
// package for the triangular system solver
// types, constants and register indexes shared by the rtl and the checker
`timescale 1ns / 1ps

package tss_pkg;

	localparam int MAX_ORDER = 16;
	localparam int IDX_W     = 4;
	localparam int ADDR_W    = 8;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [63:0] ACC_HI = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ACC_LO = 64'hC000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_MATRIX = 2'd0,
		OP_RHS    = 2'd1,
		OP_SOLVE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE = 1'd0,
		REG_MODE = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_MAC,
		ST_DIAG,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic signed [31:0] solution_value;
		logic               divide_by_zero;
		logic               saturated;
		logic               last;
	} out_item_t;

endpackage

// File: rtl/triangular_system_solver.sv
// top level of the triangular system solver
// depends on tss_pkg and tss_divider; holds the matrix, rhs and solution memories
`timescale 1ns / 1ps

// Usage:
// - in channel (in_valid/in_ready/in_data): operation 0 loads a matrix entry,
//   1 loads a right-hand-side entry, 2 starts a solve, 3 is dropped.
// - loads take one transaction a cycle; a solve occupies the block until its
//   last result has been delivered.
// - out channel (out_valid/out_ready/out_data) gives one element per row, in
//   order of computation, last marking the final row.
// - a row with k off-diagonal terms passes through set-up, reading and
//   multiply-accumulate of its k terms, a read of the diagonal, the bit-serial
//   divider (skipped for a zero diagonal) and the output register; the divider
//   sets the per-row time.
// - one memory read port per store.
// - size_in_use and triangle_mode are written through cfg_we/cfg_idx/cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
// - reset clears control state and the registers to 16 and back substitution;
//   memory contents are undefined until written, and no clearing pass is run.
// - when the receiver stalls, the result holds in the output register and the
//   solve waits; loads are not taken meanwhile.
module triangular_system_solver
	import tss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [31:0] mat_mem [MAX_ORDER*MAX_ORDER];
	logic [31:0] rhs_mem [MAX_ORDER];
	logic [31:0] sol_mem [MAX_ORDER];

	logic [CFG_W-1:0] size_q;
	logic             mode_q;
	state_t           state_q, state_d;

	logic [IDX_W-1:0] n_m1_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] cnt_q;
	logic             rd_s1;
	logic             last_row_q;

	logic signed [31:0] mat_rd_q, sol_rd_q, rhs_rd_q;
	logic signed [63:0] prod_s2;
	logic               prod_v_s2;
	logic signed [63:0] acc_q;
	logic               sat_q;
	logic signed [31:0] diag_q;

	logic               div_start, div_done, div_clip;
	logic signed [31:0] div_quo;

	logic               acc_first;
	logic [ADDR_W-1:0]  mat_raddr;
	logic [IDX_W-1:0]   n_m1;
	logic               in_fire;
	logic [64:0]        diff;
	logic               dz_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_W'(MAX_ORDER);
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIZE: size_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// zero diagonal finishes the row without the divider
	assign dz_done = (state_q == ST_DIV) && (diag_q == '0);

	// effective order minus one
	always_comb begin
		if (size_q == '0)
			n_m1 = '0;
		else if (size_q > CFG_W'(MAX_ORDER))
			n_m1 = IDX_W'(MAX_ORDER - 1);
		else
			n_m1 = IDX_W'(size_q - CFG_W'(1));
	end

	// load writes and solution write-back
	always_ff @(posedge clk) begin
		if (in_fire && op_t'(in_data.operation) == OP_MATRIX)
			mat_mem[{in_data.row, in_data.col}] <= in_data.value;
		if (in_fire && op_t'(in_data.operation) == OP_RHS)
			rhs_mem[in_data.row] <= in_data.value;
		if (state_q == ST_DIV && (div_done || dz_done))
			sol_mem[row_q] <= out_data.solution_value;
	end

	// memory reads: matrix entry, solution element, rhs
	assign mat_raddr = (state_d == ST_DIAG) ? {row_q, row_q} : {row_q, col_q};
	always_ff @(posedge clk) begin
		mat_rd_q <= mat_mem[mat_raddr];
		sol_rd_q <= sol_mem[col_q];
		rhs_rd_q <= rhs_mem[row_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && op_t'(in_data.operation) == OP_SOLVE) state_d = ST_ROW;
			ST_ROW:  state_d = ST_MAC;
			ST_MAC:  if (cnt_q == '0 && !rd_s1 && !prod_v_s2 && !acc_first) state_d = ST_DIAG;
			ST_DIAG: if (rd_s1) state_d = ST_DIV;
			ST_DIV:  if (div_done || dz_done) state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready)
					state_d = last_row_q ? ST_IDLE : ST_ROW;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_valid = (state_q == ST_OUT);
		div_start = (state_q == ST_DIAG) && rd_s1 && (mat_rd_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// pipeline flags for the read, product and first accumulate; the row and term counters follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1     <= 1'b0;
			prod_v_s2 <= 1'b0;
			acc_first <= 1'b0;
		end else begin
			rd_s1     <= 1'b0;
			prod_v_s2 <= (state_q == ST_MAC) && rd_s1;
			acc_first <= (state_q == ST_ROW);
			if (state_q == ST_MAC && cnt_q != '0)
				rd_s1 <= 1'b1;
			if (state_q == ST_MAC && cnt_q == '0 && !rd_s1 && !prod_v_s2 && !acc_first)
				rd_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			n_m1_q <= n_m1;
			row_q  <= mode_q ? '0 : n_m1;
		end
		case (state_q)
			ST_ROW: begin
				cnt_q   <= mode_q ? row_q : n_m1_q - row_q;
				col_q   <= mode_q ? '0 : row_q + IDX_W'(1);
				last_row_q <= mode_q ? (row_q == n_m1_q) : (row_q == '0);
			end
			ST_MAC: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - IDX_W'(1);
					col_q <= col_q + IDX_W'(1);
				end
			end
			ST_OUT: begin
				if (out_ready)
					row_q <= mode_q ? row_q + IDX_W'(1) : row_q - IDX_W'(1);
			end
			default: ;
		endcase
	end

	// multiply then subtract from the accumulator with clamp
	always_ff @(posedge clk) begin
		prod_s2 <= mat_rd_q * sol_rd_q;
	end

	assign diff = {acc_q[63], acc_q} - {prod_s2[63], prod_s2};

	always_ff @(posedge clk) begin
		if (acc_first) begin
			acc_q <= 64'(signed'(rhs_rd_q)) <<< 16;
			sat_q <= 1'b0;
		end else if (prod_v_s2) begin
			if ($signed(diff) > $signed({ACC_HI[63], ACC_HI})) begin
				acc_q <= ACC_HI;
				sat_q <= 1'b1;
			end else if ($signed(diff) < $signed({ACC_LO[63], ACC_LO})) begin
				acc_q <= ACC_LO;
				sat_q <= 1'b1;
			end else begin
				acc_q <= diff[63:0];
			end
		end
		if (state_q == ST_DIAG && rd_s1)
			diag_q <= mat_rd_q;
	end

	tss_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (mat_rd_q),
		.done     (div_done),
		.quotient (div_quo),
		.clipped  (div_clip)
	);

	// result fields
	always_comb begin
		out_data.index          = row_q;
		out_data.last           = last_row_q;
		out_data.divide_by_zero = (diag_q == '0);
		if (diag_q == '0) begin
			out_data.saturated      = 1'b1;
			out_data.solution_value = acc_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			out_data.saturated      = sat_q | div_clip;
			out_data.solution_value = div_quo;
		end
	end

endmodule

// File: rtl/tss_divider.sv
// iterative signed divider: 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on tss_pkg; quotient truncated toward zero, clamped to 32 bits
`timescale 1ns / 1ps

module tss_divider
	import tss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quotient,
	output logic               clipped
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dsr_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [63:0] shifted;
	logic [64:0] mag;

	// shift in the next dividend bit and try a subtract
	assign shifted = {rem_q[62:0], quo_q[63]};
	assign trial   = {1'b0, shifted} - {33'd0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[63] ? 64'(-dividend) : dividend;
			dsr_q <= divisor[31] ? 32'(-divisor) : divisor;
			neg_q <= dividend[63] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// sign the magnitude and clamp to the 32-bit range
	assign mag = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
	always_comb begin
		clipped  = 1'b0;
		quotient = mag[31:0];
		if (!neg_q && quo_q > 64'h7FFF_FFFF) begin
			clipped  = 1'b1;
			quotient = 32'sh7FFF_FFFF;
		end else if (neg_q && quo_q > 64'h8000_0000) begin
			clipped  = 1'b1;
			quotient = 32'sh8000_0000;
		end
	end

endmodule

// File: rtl/tss_checker.sv
// port-level checker for the triangular system solver
// depends on tss_pkg; bound to the top level below
`timescale 1ns / 1ps

module tss_checker
	import tss_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// no load taken while a result is shown
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during result");

	// divide by zero always reports saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |-> out_data.saturated)
		else $error("zero diagonal without saturated");

endmodule

bind triangular_system_solver tss_checker u_tss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
